// File: hw/rtl/ntin_pkg.sv
// ----------------------------------------------------------------------------
// ntin_pkg
// Shared sizes, register indexes and types for the n-ary tree index navigator.
// ----------------------------------------------------------------------------
package ntin_pkg;

    localparam int NODE_BITS      = 48;
    localparam int MAX_BRANCH     = 16;
    localparam int MAX_LEVELS     = 47;
    localparam int MIN_BRANCH     = 2;
    localparam int MIN_DEPTH      = 1;
    localparam int LEVEL_ENTRIES  = MAX_LEVELS + 2;
    localparam int LVL_BITS       = 6;
    localparam int STEP_BITS      = $clog2(LVL_BITS);
    localparam int BR_BITS        = $clog2(MAX_BRANCH + 1);
    localparam int CHILD_BITS     = $clog2(MAX_BRANCH);
    localparam int REM_BITS       = CHILD_BITS;
    localparam int PROD_BITS      = NODE_BITS + BR_BITS;
    localparam int TBL_AW         = $clog2(LEVEL_ENTRIES);
    localparam int TBL_W          = NODE_BITS + 1;
    localparam int DIV_STEP_BITS  = 8;
    localparam int DIV_CYCLES     = NODE_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [NODE_BITS-1:0] NODE_MASK    = '1;
    localparam logic [BR_BITS-1:0]   BRANCH_RESET = BR_BITS'(2);
    localparam logic [LVL_BITS-1:0]  DEPTH_RESET  = LVL_BITS'(10);

    localparam logic [CFG_IDX_BITS-1:0] CFG_BRANCHING = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DEPTH = CFG_IDX_BITS'(1);

    typedef enum logic [2:0] {
        F_BUILD,
        F_IDLE,
        F_ADDR,
        F_DATA,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        K_INNER,
        K_LEAF,
        K_BEYOND
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [LVL_BITS-1:0]   level;
        logic [NODE_BITS-1:0]  position;
        logic [NODE_BITS-1:0]  parent;
        logic [PROD_BITS-1:0]  prod;
    } t_task;

endpackage

// File: hw/rtl/ntin_ram.sv
// ----------------------------------------------------------------------------
// ntin_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ntin_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ntin_queue.sv
// ----------------------------------------------------------------------------
// ntin_queue
// Short request queue between the classifying front and the result back end.
// ----------------------------------------------------------------------------
module ntin_queue import ntin_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    input  logic  i_pop,
    output t_task o_task,
    output logic  o_full,
    output logic  o_empty
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    t_task         r_mem [QUEUE_DEPTH];
    logic [QA-1:0] r_wp;
    logic [QA-1:0] r_rp;
    logic [QC-1:0] r_cnt;
    logic [QC-1:0] n_cnt;

    assign o_full  = (r_cnt == QC'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_task  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QC'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QC'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QA'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QA'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hw/rtl/ntin_front.sv
// ----------------------------------------------------------------------------
// ntin_front
// Level-start table builder, depth search, parent divider and classifier.
// ----------------------------------------------------------------------------
module ntin_front import ntin_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rebuild,
    input  logic [BR_BITS-1:0]   i_branch,
    input  logic [LVL_BITS-1:0]  i_depth,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [NODE_BITS-1:0] i_node,
    output logic                 o_push,
    output t_task                o_task,
    input  logic                 i_full
);

    t_front_state r_state;
    t_front_state n_state;

    logic [TBL_AW-1:0]    r_bld_idx;
    logic [NODE_BITS-1:0] r_bld_start;
    logic [NODE_BITS-1:0] r_bld_width;
    logic                 r_bld_over;
    logic                 r_bld_wover;

    logic [NODE_BITS-1:0]    r_node;
    logic [LVL_BITS-1:0]     r_k;
    logic [STEP_BITS-1:0]    r_step;
    logic [NODE_BITS-1:0]    r_best;
    logic [NODE_BITS-1:0]    r_quo;
    logic [REM_BITS-1:0]     r_rem;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [PROD_BITS-1:0]    r_prod;

    logic [TBL_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic [LVL_BITS-1:0]  lim;
    logic [LVL_BITS-1:0]  cand;
    logic                 cand_ok;
    logic                 reached;
    logic                 bld_last;
    logic [NODE_BITS:0]   bld_sum;
    logic                 bld_over_n;
    logic [PROD_BITS-1:0] bld_prod;
    logic                 accept;
    logic                 div_done;
    logic [NODE_BITS-1:0] div_q_n;
    logic [REM_BITS-1:0]  div_r_n;
    logic [NODE_BITS-1:0] dividend;

    ntin_ram #(
        .WIDTH (TBL_W),
        .DEPTH (LEVEL_ENTRIES)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bld_idx),
        .i_wdata ({r_bld_over, r_bld_start}),
        .i_raddr (TBL_AW'(cand)),
        .o_rdata (ram_rdata)
    );

    assign lim      = i_depth + LVL_BITS'(1);
    assign cand     = r_k | (LVL_BITS'(1) << r_step);
    assign cand_ok  = (cand <= lim);
    assign reached  = !ram_rdata[NODE_BITS] && (r_node >= ram_rdata[NODE_BITS-1:0]);
    assign bld_last = (r_bld_idx == TBL_AW'(LEVEL_ENTRIES - 1));
    assign bld_sum  = {1'b0, r_bld_start} + {1'b0, r_bld_width};
    assign bld_over_n = r_bld_over || r_bld_wover || bld_sum[NODE_BITS];
    assign bld_prod = PROD_BITS'(r_bld_width) * PROD_BITS'(i_branch);
    assign div_done = (r_div_cnt == '0);
    assign accept   = i_in_valid && o_in_ready;
    assign dividend = (i_node == '0) ? '0 : i_node - NODE_BITS'(1);

    // radix-2 long division, several bits per cycle, remainder stays below b
    always_comb begin
        logic [NODE_BITS-1:0] q;
        logic [REM_BITS-1:0]  rem;
        logic [BR_BITS-1:0]   sh;
        q   = r_quo;
        rem = r_rem;
        sh  = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            sh = {rem, q[NODE_BITS-1]};
            q  = {q[NODE_BITS-2:0], 1'b0};
            if (sh >= i_branch) begin
                sh   = sh - i_branch;
                q[0] = 1'b1;
            end
            rem = sh[REM_BITS-1:0];
        end
        div_q_n = q;
        div_r_n = rem;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_BUILD: begin
                if (bld_last) begin
                    n_state = F_IDLE;
                end
            end
            F_IDLE: begin
                if (accept) begin
                    n_state = F_ADDR;
                end
            end
            F_ADDR: begin
                if (cand_ok) begin
                    n_state = F_DATA;
                end else if (r_step == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_DATA: begin
                if (r_step == '0) begin
                    n_state = F_PUSH;
                end else begin
                    n_state = F_ADDR;
                end
            end
            F_PUSH: begin
                if (!i_full && div_done) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_BUILD;
            end
        endcase
        if (i_rebuild) begin
            n_state = F_BUILD;
        end
    end

    always_comb begin
        o_in_ready = (r_state == F_IDLE) && !i_rebuild;
        ram_we     = (r_state == F_BUILD);
        o_push     = (r_state == F_PUSH) && !i_full && div_done;
    end

    always_comb begin
        o_task.parent = r_quo;
        o_task.prod   = r_prod;
        if (r_k == lim) begin
            o_task.kind     = K_BEYOND;
            o_task.level    = '0;
            o_task.position = '0;
        end else begin
            o_task.kind     = (r_k == i_depth) ? K_LEAF : K_INNER;
            o_task.level    = r_k;
            o_task.position = r_node - r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_BUILD;
            r_bld_idx   <= '0;
            r_bld_start <= '0;
            r_bld_width <= NODE_BITS'(1);
            r_bld_over  <= 1'b0;
            r_bld_wover <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_rebuild) begin
                r_bld_idx   <= '0;
                r_bld_start <= '0;
                r_bld_width <= NODE_BITS'(1);
                r_bld_over  <= 1'b0;
                r_bld_wover <= 1'b0;
            end else if (r_state == F_BUILD) begin
                r_bld_idx   <= r_bld_idx + TBL_AW'(1);
                r_bld_over  <= bld_over_n;
                r_bld_start <= bld_over_n ? NODE_MASK : bld_sum[NODE_BITS-1:0];
                if (r_bld_wover || (bld_prod[PROD_BITS-1:NODE_BITS] != '0)) begin
                    r_bld_wover <= 1'b1;
                    r_bld_width <= NODE_MASK;
                end else begin
                    r_bld_width <= bld_prod[NODE_BITS-1:0];
                end
            end
            if (accept) begin
                r_div_cnt <= DIV_CNT_BITS'(DIV_CYCLES);
            end else if (!div_done) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_node <= i_node;
            r_k    <= '0;
            r_best <= '0;
            r_step <= STEP_BITS'(LVL_BITS - 1);
            r_prod <= PROD_BITS'(i_node) * PROD_BITS'(i_branch);
            r_quo  <= dividend;
            r_rem  <= '0;
        end else begin
            if (r_state == F_ADDR && !cand_ok) begin
                r_step <= r_step - STEP_BITS'(1);
            end
            if (r_state == F_DATA) begin
                r_step <= r_step - STEP_BITS'(1);
                if (reached) begin
                    r_k    <= cand;
                    r_best <= ram_rdata[NODE_BITS-1:0];
                end
            end
            if (!div_done) begin
                r_quo <= div_q_n;
                r_rem <= div_r_n;
            end
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_ADDR || r_state == F_DATA || r_state == F_PUSH) |-> (r_k <= lim))
        else $error("depth search ran past the tree");

    a_probe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DATA) |-> ($past(r_state) == F_ADDR))
        else $error("table data taken without a probe");

endmodule

// File: hw/rtl/ntin_back.sv
// ----------------------------------------------------------------------------
// ntin_back
// Result generator: walks request children, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ntin_back import ntin_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [BR_BITS-1:0]   i_branch,
    input  t_task                i_task,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LVL_BITS-1:0]  o_level,
    output logic [NODE_BITS-1:0] o_position,
    output logic [NODE_BITS-1:0] o_parent,
    output logic [NODE_BITS-1:0] o_child,
    output logic                 o_has_child,
    output logic                 o_out_of_tree,
    output logic                 o_last
);

    logic [CHILD_BITS-1:0] r_x;
    logic                  r_out_valid;
    logic [LVL_BITS-1:0]   r_level;
    logic [NODE_BITS-1:0]  r_position;
    logic [NODE_BITS-1:0]  r_parent;
    logic [NODE_BITS-1:0]  r_child;
    logic                  r_has_child;
    logic                  r_out_of_tree;
    logic                  r_last;

    logic                  load;
    logic                  fire;
    logic [BR_BITS-1:0]    bm1;
    logic                  last_x;
    logic [PROD_BITS-1:0]  csum;
    logic                  fits;
    logic [NODE_BITS-1:0]  n_child;
    logic                  n_has_child;
    logic                  n_out_of_tree;
    logic                  n_last;

    assign load   = !r_out_valid || i_out_ready;
    assign fire   = load && !i_empty;
    assign bm1    = i_branch - BR_BITS'(1);
    assign last_x = ({1'b0, r_x} == bm1);
    assign csum   = i_task.prod + PROD_BITS'(r_x) + PROD_BITS'(1);
    assign fits   = (csum[PROD_BITS-1:NODE_BITS] == '0);
    assign o_pop  = fire && n_last;

    always_comb begin
        case (i_task.kind)
            K_INNER: begin
                n_child       = fits ? csum[NODE_BITS-1:0] : '0;
                n_has_child   = fits;
                n_out_of_tree = !fits;
                n_last        = last_x;
            end
            K_BEYOND: begin
                n_child       = '0;
                n_has_child   = 1'b0;
                n_out_of_tree = 1'b1;
                n_last        = 1'b1;
            end
            default: begin
                n_child       = '0;
                n_has_child   = 1'b0;
                n_out_of_tree = 1'b0;
                n_last        = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_x         <= '0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
            r_x         <= n_last ? '0 : r_x + CHILD_BITS'(1);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_level       <= i_task.level;
            r_position    <= i_task.position;
            r_parent      <= i_task.parent;
            r_child       <= n_child;
            r_has_child   <= n_has_child;
            r_out_of_tree <= n_out_of_tree;
            r_last        <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_level       = r_level;
    assign o_position    = r_position;
    assign o_parent      = r_parent;
    assign o_child       = r_child;
    assign o_has_child   = r_has_child;
    assign o_out_of_tree = r_out_of_tree;
    assign o_last        = r_last;

    a_run_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x != '0) |-> !i_empty)
        else $error("child run lost its request");

endmodule

// File: hw/rtl/nary_tree_index_navigator.sv
// ----------------------------------------------------------------------------
// nary_tree_index_navigator
// Per node index of an implicit complete tree: depth, offset, parent, children.
// ----------------------------------------------------------------------------
// After reset and after every accepted write to the branching or max_depth
// register the block rebuilds its 49-entry level-start table, one entry a
// cycle, and takes no node until the table is complete. A node request then
// passes a six-step binary search over the level-start memory (a skipped
// step uses the address state only, a probe also the data state behind the
// registered read port) while the parent is divided out 8 bits a cycle, and
// enters the queue once both are done and the queue has room; the next node
// is taken after that push. The back end delivers one result a cycle while
// the output is ready and the queue holds a request: b results for a node
// with children, one for a node at the depth limit or beyond the tree. A
// two-entry queue between the two lets the slower side set the rate.
// ----------------------------------------------------------------------------
module nary_tree_index_navigator import ntin_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [NODE_BITS-1:0]     i_node,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [LVL_BITS-1:0]      o_level,
    output logic [NODE_BITS-1:0]     o_position,
    output logic [NODE_BITS-1:0]     o_parent,
    output logic [NODE_BITS-1:0]     o_child,
    output logic                     o_has_child,
    output logic                     o_out_of_tree,
    output logic                     o_last
);

    logic [BR_BITS-1:0]  r_branch;
    logic [LVL_BITS-1:0] r_max_depth;
    logic [BR_BITS-1:0]  eff_b;
    logic [LVL_BITS-1:0] eff_d;
    logic                cfg_hit;
    logic                cfg_known;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_task front_task;
    t_task head_task;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (i_cfg_index)
            CFG_BRANCHING: cfg_known = 1'b1;
            CFG_MAX_DEPTH: cfg_known = 1'b1;
            default:       cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch    <= BRANCH_RESET;
            r_max_depth <= DEPTH_RESET;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                CFG_BRANCHING: r_branch    <= i_cfg_data[BR_BITS-1:0];
                CFG_MAX_DEPTH: r_max_depth <= i_cfg_data[LVL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // out-of-range settings clamp to the nearest legal value
    always_comb begin
        if (r_branch < BR_BITS'(MIN_BRANCH)) begin
            eff_b = BR_BITS'(MIN_BRANCH);
        end else if (r_branch > BR_BITS'(MAX_BRANCH)) begin
            eff_b = BR_BITS'(MAX_BRANCH);
        end else begin
            eff_b = r_branch;
        end
        if (r_max_depth < LVL_BITS'(MIN_DEPTH)) begin
            eff_d = LVL_BITS'(MIN_DEPTH);
        end else if (r_max_depth > LVL_BITS'(MAX_LEVELS)) begin
            eff_d = LVL_BITS'(MAX_LEVELS);
        end else begin
            eff_d = r_max_depth;
        end
    end

    ntin_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rebuild  (cfg_hit && cfg_known),
        .i_branch   (eff_b),
        .i_depth    (eff_d),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_node     (i_node),
        .o_push     (push),
        .o_task     (front_task),
        .i_full     (full)
    );

    ntin_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (front_task),
        .i_pop   (pop),
        .o_task  (head_task),
        .o_full  (full),
        .o_empty (empty)
    );

    ntin_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_branch      (eff_b),
        .i_task        (head_task),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_position    (o_position),
        .o_parent      (o_parent),
        .o_child       (o_child),
        .o_has_child   (o_has_child),
        .o_out_of_tree (o_out_of_tree),
        .o_last        (o_last)
    );

endmodule
